// ----- rtl/sbm_pkg.sv -----
// Shared constants, types and codes of the separable 3x3 box mean block.
package sbm_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int NUM_LANES    = 4;
  localparam int LANE_W       = 8;
  localparam int PIX_W        = NUM_LANES * LANE_W;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 16;
  localparam int CHAN_CNT_W   = 3;
  localparam int IMG_W_W      = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Division by three of a lane sum below 768: multiply by 683 and shift by 11.
  localparam int SUM_W        = LANE_W + 2;
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;
  localparam int PROD_W       = 2 * SUM_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2
  } reg_idx_t;

  // What one vertical step does with its column of the line stores.
  typedef enum logic [1:0] {
    OP_PIX   = 2'd0,
    OP_ROW0  = 2'd1,
    OP_DRAIN = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    col_t     col;
    pix_t     h;
    logic     frame_end;
    logic     run_end;
  } op_t;

  // Entry of the two line stores at one column: a is the older row.
  typedef struct packed {
    pix_t b;
    pix_t a;
  } line_pair_t;

  typedef struct packed {
    logic rd_en;
    col_t rd_addr;
    logic wr_en;
    col_t wr_addr;
  } mem_req_t;

endpackage

// ----- rtl/sbm_if.sv -----
// Channel interfaces of the box mean block: pixel input, result output, register writes.
interface sbm_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [sbm_pkg::LANE_W-1:0]  sample_0;
  logic [sbm_pkg::LANE_W-1:0]  sample_1;
  logic [sbm_pkg::LANE_W-1:0]  sample_2;
  logic [sbm_pkg::LANE_W-1:0]  sample_3;

  modport source (output valid, command, sample_0, sample_1, sample_2, sample_3,
                  input ready);
  modport sink (input valid, command, sample_0, sample_1, sample_2, sample_3,
                output ready);
endinterface

interface sbm_res_if;
  logic                        valid;
  logic                        ready;
  logic [sbm_pkg::LANE_W-1:0]  mean_0;
  logic [sbm_pkg::LANE_W-1:0]  mean_1;
  logic [sbm_pkg::LANE_W-1:0]  mean_2;
  logic [sbm_pkg::LANE_W-1:0]  mean_3;
  logic                        frame_end;
  logic                        run_end;

  modport source (output valid, mean_0, mean_1, mean_2, mean_3, frame_end, run_end,
                  input ready);
  modport sink (input valid, mean_0, mean_1, mean_2, mean_3, frame_end, run_end,
                output ready);
endinterface

interface sbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbm_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [sbm_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/sbm_lane.sv -----
// One channel lane: rounded mean of three 8-bit values, (x+y+z+1)/3.
module sbm_lane (
  input  logic [sbm_pkg::LANE_W-1:0] x,
  input  logic [sbm_pkg::LANE_W-1:0] y,
  input  logic [sbm_pkg::LANE_W-1:0] z,
  output logic [sbm_pkg::LANE_W-1:0] m
);

  logic [sbm_pkg::SUM_W-1:0]  sum;
  logic [sbm_pkg::PROD_W-1:0] prod;

  // The reciprocal product is exact for every sum up to 766.
  assign sum  = sbm_pkg::SUM_W'(x) + sbm_pkg::SUM_W'(y) + sbm_pkg::SUM_W'(z)
              + sbm_pkg::SUM_W'(1);
  assign prod = sbm_pkg::PROD_W'(sum) * sbm_pkg::PROD_W'(sbm_pkg::RECIP3);
  assign m    = prod[sbm_pkg::RECIP3_SHIFT +: sbm_pkg::LANE_W];

endmodule

// ----- rtl/sbm_line_mem.sv -----
// The two line stores of horizontal results, one read and one write port, read-first.
module sbm_line_mem (
  input  logic                clk,
  input  sbm_pkg::mem_req_t   req,
  input  sbm_pkg::line_pair_t wr_data,
  output sbm_pkg::line_pair_t rd_data
);

  sbm_pkg::pix_t line_store_a [sbm_pkg::MAX_WIDTH];
  sbm_pkg::pix_t line_store_b [sbm_pkg::MAX_WIDTH];
  sbm_pkg::pix_t rd_a_r;
  sbm_pkg::pix_t rd_b_r;

  // A read in the same cycle as a write to the same column returns the old entry.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_r <= line_store_a[req.rd_addr];
      rd_b_r <= line_store_b[req.rd_addr];
    end
    if (req.wr_en) begin
      line_store_a[req.wr_addr] <= wr_data.a;
      line_store_b[req.wr_addr] <= wr_data.b;
    end
  end

  assign rd_data.a = rd_a_r;
  assign rd_data.b = rd_b_r;

endmodule

// ----- rtl/separable_box_mean_3x3_unit.sv -----
// Top level: streaming 3x3 box mean with replicated borders, four channel lanes.
// Path: an accepted item's vertical step is registered in stage B, its result then in the output register;
// the second step of a row-end pixel first waits in the pending register.
// Throughput: one item per cycle while the output is taken; a pixel that ends a row past column zero
// holds off the next item, since its two vertical steps share the single read port of the line stores.
// Reset (synchronous, active low) clears positions and valid bits and sets each configuration register to one;
// the line stores are not cleared, since the first row of a frame fills them.
module separable_box_mean_3x3_unit (
  input  logic       clk,
  input  logic       rst_n,
  sbm_cfg_if.sink    cfg_chan,
  sbm_pix_if.sink    in_chan,
  sbm_res_if.source  out_chan
);

  localparam int NL = sbm_pkg::NUM_LANES;
  localparam int LW = sbm_pkg::LANE_W;
  localparam int CW = sbm_pkg::COL_W;
  localparam int RW = sbm_pkg::ROW_W;

  // Configuration registers.
  logic [sbm_pkg::CHAN_CNT_W-1:0] chan_cnt_r;
  logic [sbm_pkg::IMG_W_W-1:0]    img_w_r;
  logic [RW-1:0]                  img_h_r;

  // Raster position and horizontal window state.
  sbm_pkg::pix_t prev_r, prev_nxt;
  sbm_pkg::pix_t pprev_r, pprev_nxt;
  sbm_pkg::col_t col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  sbm_pkg::col_t drain_pos_r, drain_pos_nxt;
  logic          awaiting_r, awaiting_nxt;

  // Second vertical step of a row-end pixel waits here until stage B is free.
  logic          pend_valid_r, pend_valid_nxt;
  sbm_pkg::op_t  pend_op_r;

  // Stage B: the line store read of this op has returned.
  logic          b_valid_r, b_valid_nxt;
  sbm_pkg::op_t  b_op_r;

  // Last line store write, forwarded when the next op reads the same column.
  logic                lw_valid_r;
  sbm_pkg::col_t       lw_addr_r;
  sbm_pkg::line_pair_t lw_data_r;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  sbm_pkg::pix_t out_mean_r;
  logic          out_frame_end_r;
  logic          out_run_end_r;

  // Effective configuration.
  sbm_pkg::col_t                  w_last;
  logic [RW-1:0]                  h_last;
  logic [sbm_pkg::CHAN_CNT_W-1:0] ch_eff;

  sbm_pkg::pix_t pix_in, left_pix, h1, h2;
  logic          row_end, drain_last;
  logic          accept, drain_go, pix_go, op2_go;
  logic          b_emits, b_adv, b_free, in_ready;
  logic          op1_valid, issue_pend, issue;
  sbm_pkg::op_t  op1, op2, issue_op;
  sbm_pkg::op_kind_t pix_kind;

  sbm_pkg::mem_req_t   mem_req;
  sbm_pkg::line_pair_t mem_wr_data, mem_rd_data, cur;
  logic                fwd;
  sbm_pkg::pix_t       vz, vmean, merged;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes are always taken; an index past the list is dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= sbm_pkg::CHAN_CNT_W'(1);
      img_w_r    <= sbm_pkg::IMG_W_W'(1);
      img_h_r    <= RW'(1);
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        sbm_pkg::REG_CHANNEL_COUNT: begin
          chan_cnt_r <= cfg_chan.wdata[sbm_pkg::CHAN_CNT_W-1:0];
        end
        sbm_pkg::REG_IMAGE_WIDTH: begin
          img_w_r <= cfg_chan.wdata[sbm_pkg::IMG_W_W-1:0];
        end
        sbm_pkg::REG_IMAGE_HEIGHT: begin
          img_h_r <= cfg_chan.wdata[RW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings saturate: zero acts as one; a width or channel count too large acts as its maximum.
  always_comb begin
    if (img_w_r == '0) begin
      w_last = '0;
    end else if (32'(img_w_r) > sbm_pkg::MAX_WIDTH) begin
      w_last = CW'(sbm_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = CW'(img_w_r - sbm_pkg::IMG_W_W'(1));
    end
    h_last = (img_h_r == '0) ? '0 : img_h_r - RW'(1);
    if (chan_cnt_r == '0) begin
      ch_eff = sbm_pkg::CHAN_CNT_W'(1);
    end else if (32'(chan_cnt_r) > sbm_pkg::MAX_CHANNELS) begin
      ch_eff = sbm_pkg::CHAN_CNT_W'(sbm_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = chan_cnt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Front: horizontal pass. Each lane instance handles one channel of the pixel.
  assign pix_in   = {in_chan.sample_3, in_chan.sample_2, in_chan.sample_1, in_chan.sample_0};
  assign left_pix = (col_r == CW'(1)) ? prev_r : pprev_r;
  assign row_end  = col_r >= w_last;
  assign drain_last = drain_pos_r >= w_last;

  for (genvar j = 0; j < NL; j++) begin : g_hlane
    // Mean around the previous column.
    sbm_lane u_h1 (
      .x (left_pix[j*LW +: LW]),
      .y (prev_r[j*LW +: LW]),
      .z (pix_in[j*LW +: LW]),
      .m (h1[j*LW +: LW])
    );
    // Mean at the last column, with the edge pixel standing in for its right neighbor.
    sbm_lane u_h2 (
      .x (prev_r[j*LW +: LW]),
      .y (pix_in[j*LW +: LW]),
      .z (pix_in[j*LW +: LW]),
      .m (h2[j*LW +: LW])
    );
  end

  // Stage B moves on unless its result has to wait for a full output register.
  assign b_emits  = b_op_r.kind != sbm_pkg::OP_ROW0;
  assign b_adv    = b_valid_r && (!b_emits || !out_valid_r || out_chan.ready);
  assign b_free   = !b_valid_r || b_adv;
  assign in_ready = !pend_valid_r && b_free;
  assign in_chan.ready = in_ready;

  assign accept   = in_chan.valid && in_ready;
  assign drain_go = accept && in_chan.command && awaiting_r;
  assign pix_go   = accept && !in_chan.command && !awaiting_r;
  assign op2_go   = pix_go && (col_r != '0) && row_end;
  assign pix_kind = (row_r == '0) ? sbm_pkg::OP_ROW0 : sbm_pkg::OP_PIX;

  // Build the vertical steps that the accepted item causes. The first row only fills
  // the stores; a drain replicates the bottom row.
  always_comb begin
    op1       = '0;
    op1.kind  = sbm_pkg::OP_PIX;
    op1_valid = 1'b0;
    if (drain_go) begin
      op1_valid     = 1'b1;
      op1.kind      = sbm_pkg::OP_DRAIN;
      op1.col       = drain_pos_r;
      op1.frame_end = drain_last;
      op1.run_end   = 1'b1;
    end else if (pix_go && ((col_r != '0) || row_end)) begin
      op1_valid   = 1'b1;
      op1.kind    = pix_kind;
      op1.col     = (col_r == '0) ? '0 : col_r - CW'(1);
      op1.h       = (col_r == '0) ? pix_in : h1;
      op1.run_end = !op2_go;
    end

    op2           = '0;
    op2.kind      = pix_kind;
    op2.col       = col_r;
    op2.h         = h2;
    op2.run_end   = 1'b1;
  end

  assign issue_pend = pend_valid_r && b_free;
  assign issue      = issue_pend || op1_valid;
  assign issue_op   = issue_pend ? pend_op_r : op1;

  assign pend_valid_nxt = op2_go ? 1'b1 : (issue_pend ? 1'b0 : pend_valid_r);
  assign b_valid_nxt    = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);

  // Raster position update.
  always_comb begin
    prev_nxt      = prev_r;
    pprev_nxt     = pprev_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_pos_nxt = drain_pos_r;
    awaiting_nxt  = awaiting_r;
    if (pix_go) begin
      pprev_nxt = prev_r;
      prev_nxt  = pix_in;
      if (row_end) begin
        col_nxt = '0;
        if (row_r >= h_last) begin
          awaiting_nxt  = 1'b1;
          drain_pos_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end else if (drain_go) begin
      if (drain_last) begin
        // Frame done: everything returns to the start of a new frame.
        awaiting_nxt  = 1'b0;
        drain_pos_nxt = '0;
        col_nxt       = '0;
        row_nxt       = '0;
        prev_nxt      = '0;
        pprev_nxt     = '0;
      end else begin
        drain_pos_nxt = drain_pos_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The read is issued with the op; the write happens as stage B leaves.
  always_comb begin
    mem_req.rd_en   = issue;
    mem_req.rd_addr = issue_op.col;
    mem_req.wr_en   = b_adv && (b_op_r.kind != sbm_pkg::OP_DRAIN);
    mem_req.wr_addr = b_op_r.col;
  end

  sbm_line_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // The read-first store misses a write made at the edge of this op's read.
  assign fwd = lw_valid_r && (lw_addr_r == b_op_r.col);
  assign cur = fwd ? lw_data_r : mem_rd_data;

  // Rows shift up one: the older row takes the newer, the newer takes this result.
  // In the first row both take it, so the top row replicates itself.
  always_comb begin
    mem_wr_data.b = b_op_r.h;
    mem_wr_data.a = (b_op_r.kind == sbm_pkg::OP_ROW0) ? b_op_r.h : cur.b;
  end

  // ---------------------------------------------------------------------------
  // Stage B: vertical pass in the lanes, then the merge zeroes the inactive lanes.
  assign vz = (b_op_r.kind == sbm_pkg::OP_DRAIN) ? cur.b : b_op_r.h;

  for (genvar j = 0; j < NL; j++) begin : g_vlane
    sbm_lane u_v (
      .x (cur.a[j*LW +: LW]),
      .y (cur.b[j*LW +: LW]),
      .z (vz[j*LW +: LW]),
      .m (vmean[j*LW +: LW])
    );
    assign merged[j*LW +: LW] = (32'(ch_eff) > j) ? vmean[j*LW +: LW] : LW'(0);
  end

  assign out_valid_nxt = (b_adv && b_emits) ? 1'b1
                       : ((out_valid_r && out_chan.ready) ? 1'b0 : out_valid_r);

  // ---------------------------------------------------------------------------
  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      pprev_r      <= '0;
      col_r        <= '0;
      row_r        <= '0;
      drain_pos_r  <= '0;
      awaiting_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      b_valid_r    <= 1'b0;
      lw_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_r       <= prev_nxt;
      pprev_r      <= pprev_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      drain_pos_r  <= drain_pos_nxt;
      awaiting_r   <= awaiting_nxt;
      pend_valid_r <= pend_valid_nxt;
      b_valid_r    <= b_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (mem_req.wr_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op2_go) begin
      pend_op_r <= op2;
    end
    if (issue) begin
      b_op_r <= issue_op;
    end
    if (mem_req.wr_en) begin
      lw_addr_r <= mem_req.wr_addr;
      lw_data_r <= mem_wr_data;
    end
    if (b_adv && b_emits) begin
      out_mean_r      <= merged;
      out_frame_end_r <= b_op_r.frame_end;
      out_run_end_r   <= b_op_r.run_end;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.mean_0    = out_mean_r[0*LW +: LW];
  assign out_chan.mean_1    = out_mean_r[1*LW +: LW];
  assign out_chan.mean_2    = out_mean_r[2*LW +: LW];
  assign out_chan.mean_3    = out_mean_r[3*LW +: LW];
  assign out_chan.frame_end = out_frame_end_r;
  assign out_chan.run_end   = out_run_end_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_pend_after_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    op2_go |=> pend_valid_r)
    else $error("row-end pixel did not leave its second step pending");

  a_pend_behind_b: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> b_valid_r)
    else $error("pending step without its first step in stage B");

  a_drain_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (col_r == '0))
    else $error("column moved while the last row drains");

  a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_run_end_r)
    else $error("frame end result not marked as last of its item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (b_adv && b_emits && out_valid_r) |-> out_chan.ready)
    else $error("output register overwritten before it was taken");

endmodule
